[rtl/core/altitude_pid_filtered_derivative_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion helpers shared by the altitude PID core.
// Both forms are clocked on clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ALTITUDE_PID_FILTERED_DERIVATIVE_TOP_DEFINES_SVH
`define ALTITUDE_PID_FILTERED_DERIVATIVE_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define APFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define APFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/apfd_pkg.sv]
// ----------------------------------------------------------------------------
// apfd_pkg
// Widths, constants, register indexes, sequencer states and divider
// request/response types for the altitude PID core.
// ----------------------------------------------------------------------------
`default_nettype none

package apfd_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int TIME_W        = 32;

  localparam int US_PER_S   = 1000000;
  localparam int US_W       = $clog2(US_PER_S + 1);
  localparam int DT_DEFAULT = 10000;
  localparam int DT_MAX     = 100000;
  localparam int DT_W       = $clog2(DT_MAX + 1);

  localparam int ALPHA_W  = FRACTION_BITS + 1;
  localparam int ILIM_W   = VALUE_WIDTH - 1;
  localparam int PROD_W   = 2 * VALUE_WIDTH;
  localparam int ACC_W    = VALUE_WIDTH + FRACTION_BITS + 2;
  localparam int SUM_W    = VALUE_WIDTH + 2;
  localparam int WIDE_W   = VALUE_WIDTH + 4;

  // divider: two quotient bits per cycle, so the dividend width is even
  localparam int DIV_W     = 2 * ((VALUE_WIDTH + US_W + 3) / 2);
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ALTITUDE_TARGET  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P           = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I           = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D           = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_LIMIT      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 3'd6;

  localparam logic [VALUE_WIDTH-1:0] RST_GAIN_P           = VALUE_WIDTH'(6554);
  localparam logic [ILIM_W-1:0]      RST_INTEGRAL_LIMIT   = ILIM_W'(655360);
  localparam logic [VALUE_WIDTH-1:0] RST_DRIVE_LIMIT      = VALUE_WIDTH'(6553600);
  localparam logic [ALPHA_W-1:0]     RST_SMOOTHING_WEIGHT = ALPHA_W'(13107);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_IMUL,
    ST_IDIV_GO,
    ST_IDIV,
    ST_IUPD,
    ST_DDIV_GO,
    ST_DDIV,
    ST_FMUL0,
    ST_FMUL1,
    ST_FACC,
    ST_FUPD,
    ST_GMUL_P,
    ST_GMUL_I,
    ST_GMUL_D,
    ST_GTERM,
    ST_GSUM,
    ST_FINAL
  } apfd_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [US_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/apfd_in_if.sv]
// ----------------------------------------------------------------------------
// apfd_in_if
// Sample channel: one timestamped altitude word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface apfd_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [apfd_pkg::VALUE_WIDTH-1:0]  altitude_sample;
  logic        [apfd_pkg::TIME_W-1:0]       sample_time_us;

  modport source (output valid, output altitude_sample, output sample_time_us,
                  input ready);
  modport sink   (input valid, input altitude_sample, input sample_time_us,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/apfd_out_if.sv]
// ----------------------------------------------------------------------------
// apfd_out_if
// Drive channel: one drive word and its clamp flag per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface apfd_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [apfd_pkg::VALUE_WIDTH-1:0]  drive_value;
  logic                                     drive_clamped;

  modport source (output valid, output drive_value, output drive_clamped,
                  input ready);
  modport sink   (input valid, input drive_value, input drive_clamped,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/apfd_cfg_if.sv]
// ----------------------------------------------------------------------------
// apfd_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface apfd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [apfd_pkg::REG_IDX_W-1:0]      reg_index;
  logic [apfd_pkg::VALUE_WIDTH-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

[rtl/core/apfd_div.sv]
// ----------------------------------------------------------------------------
// apfd_div
// Unsigned restoring divider, two quotient bits per cycle. A start pulse
// loads the operands; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module apfd_div (
  input  logic               clk,
  input  logic               rst,
  input  apfd_pkg::div_req_t req,
  output apfd_pkg::div_rsp_t rsp
);

  localparam int DW   = apfd_pkg::DIV_W;
  localparam int RW   = apfd_pkg::US_W;
  localparam int CW   = apfd_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] LAST = CW'(apfd_pkg::DIV_STEPS - 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW-1:0] work;
  logic [RW-1:0] rem;
  logic [RW-1:0] den;

  logic [RW:0]   t1, t2, s1, s2;
  logic          ge1, ge2;
  logic [RW-1:0] r1, r2;
  logic [DW-1:0] work_next;

  // work shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    t1  = {rem, work[DW-1]};
    s1  = t1 - {1'b0, den};
    ge1 = (t1 >= {1'b0, den});
    r1  = ge1 ? s1[RW-1:0] : t1[RW-1:0];
    t2  = {r1, work[DW-2]};
    s2  = t2 - {1'b0, den};
    ge2 = (t2 >= {1'b0, den});
    r2  = ge2 ? s2[RW-1:0] : t2[RW-1:0];
    work_next = {work[DW-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == LAST)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work <= req.num;
      rem  <= '0;
      den  <= req.den;
      cnt  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= r2;
      cnt  <= cnt + 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = work;

endmodule

`default_nettype wire

[rtl/core/altitude_pid_filtered_derivative_top.sv]
// ----------------------------------------------------------------------------
// altitude_pid_filtered_derivative_top: altitude PID, filtered derivative
// Each sample word runs through two serial divisions and one shared multiplier;
// a new sample word is accepted only while the sequencer is idle.
// Sync reset restores register defaults and clears integrator and filter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "altitude_pid_filtered_derivative_top_defines.svh"

module altitude_pid_filtered_derivative_top (
  input  logic        clk,
  input  logic        rst,
  apfd_in_if.sink     sample,
  apfd_out_if.source  drive,
  apfd_cfg_if.sink    cfg
);

  localparam int VW     = apfd_pkg::VALUE_WIDTH;
  localparam int FB     = apfd_pkg::FRACTION_BITS;
  localparam int PW     = apfd_pkg::PROD_W;
  localparam int AW     = apfd_pkg::ACC_W;
  localparam int SW     = apfd_pkg::SUM_W;
  localparam int WW     = apfd_pkg::WIDE_W;
  localparam int DW     = apfd_pkg::DIV_W;
  localparam int UW     = apfd_pkg::US_W;
  localparam int TW     = apfd_pkg::TIME_W;
  localparam int DTW    = apfd_pkg::DT_W;
  localparam int ALW    = apfd_pkg::ALPHA_W;
  localparam int ILW    = apfd_pkg::ILIM_W;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [PW-1:0]  HALF_RANGE = PW'(1) << (VW - 1);
  localparam logic [PW-1:0]  ROUND_Q    = PW'(1) << (FB - 1);
  localparam logic [ALW-1:0] ONE_Q      = ALW'(1) << FB;

  // ---------------------------------------------------------------- helpers
  function automatic logic [VW-1:0] mag_of(input logic signed [VW:0] x);
    logic [VW:0] m;
    m = x[VW] ? (~$unsigned(x) + 1'b1) : $unsigned(x);
    return m[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] from_mag(input logic neg,
                                                    input logic [PW-1:0] m);
    logic [VW-1:0] lo;
    lo = m[VW-1:0];
    if (neg) begin
      if (m > HALF_RANGE) return VMIN;
      return $signed(~lo + 1'b1);
    end
    if (m > PW'($unsigned(VMAX))) return VMAX;
    return $signed(lo);
  endfunction

  function automatic logic signed [VW-1:0] sat_wide(input logic signed [WW-1:0] x);
    if (x > WW'(VMAX)) return VMAX;
    if (x < WW'(VMIN)) return VMIN;
    return x[VW-1:0];
  endfunction

  function automatic logic signed [AW-1:0] signed_prod(input logic neg,
                                                       input logic [PW-1:0] p);
    logic signed [AW-1:0] v;
    v = $signed(p[AW-1:0]);
    return neg ? -v : v;
  endfunction

  // Q-format gain product, rounded half away from zero
  function automatic logic signed [VW-1:0] gain_term(input logic neg,
                                                     input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p + ROUND_Q) >> FB;
    return from_mag(neg, r);
  endfunction

  // ---------------------------------------------------------------- registers
  logic signed [VW-1:0]  altitude_target;
  logic signed [VW-1:0]  gain_p;
  logic signed [VW-1:0]  gain_i;
  logic signed [VW-1:0]  gain_d;
  logic        [ILW-1:0] integral_limit;
  logic signed [VW-1:0]  drive_limit;
  logic        [ALW-1:0] smoothing_weight;

  logic                  awaiting_first;
  logic        [TW-1:0]  previous_time_us;
  logic signed [VW-1:0]  error_integral;
  logic signed [VW-1:0]  previous_error;
  logic signed [VW-1:0]  smoothed_derivative;

  apfd_pkg::apfd_state_t state, state_next;

  logic signed [VW-1:0]  err;
  logic        [DTW-1:0] dt;
  logic signed [VW:0]    diff;
  logic signed [VW-1:0]  incr;
  logic signed [VW-1:0]  raw;
  logic signed [AW-1:0]  acc;
  logic signed [VW-1:0]  term;
  logic signed [SW-1:0]  sum;
  logic        [PW-1:0]  prod;
  logic                  prod_neg;

  logic                  out_valid;
  logic signed [VW-1:0]  drive_value_q;
  logic                  drive_clamped_q;

  logic        [VW-1:0]  mul_a, mul_b;
  logic                  mul_neg;
  apfd_pkg::div_req_t    div_req;
  apfd_pkg::div_rsp_t    div_rsp;

  logic        [TW-1:0]  time_diff, dt_raw;
  logic        [DTW-1:0] dt_pick;
  logic        [ALW-1:0] alpha;
  logic signed [VW-1:0]  int_sum, int_lim, int_clamped;
  logic signed [VW-1:0]  drive_sat;
  logic                  out_free;

  assign sample.ready        = (state == apfd_pkg::ST_IDLE);
  assign cfg.ready           = 1'b1;
  assign drive.valid         = out_valid;
  assign drive.drive_value   = drive_value_q;
  assign drive.drive_clamped = drive_clamped_q;

  assign out_free = !out_valid || drive.ready;

  // ---------------------------------------------------------------- datapath comb
  always_comb begin
    time_diff = sample.sample_time_us - previous_time_us;
    dt_raw    = awaiting_first ? TW'(apfd_pkg::DT_DEFAULT) : time_diff;
    if ((dt_raw == '0) || (dt_raw > TW'(apfd_pkg::DT_MAX))) begin
      dt_pick = DTW'(apfd_pkg::DT_DEFAULT);
    end else begin
      dt_pick = dt_raw[DTW-1:0];
    end

    alpha = smoothing_weight[ALW-1] ? ONE_Q : smoothing_weight;

    int_sum = sat_wide(WW'(error_integral) + WW'(incr));
    int_lim = $signed({1'b0, integral_limit});
    if (int_sum > int_lim) begin
      int_clamped = int_lim;
    end else if (int_sum < -int_lim) begin
      int_clamped = -int_lim;
    end else begin
      int_clamped = int_sum;
    end

    drive_sat = sat_wide(WW'(sum));
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apfd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    mul_neg    = 1'b0;
    div_req    = '0;
    case (state)
      apfd_pkg::ST_IDLE: begin
        if (sample.valid) state_next = apfd_pkg::ST_IMUL;
      end
      apfd_pkg::ST_IMUL: begin
        mul_a      = mag_of({err[VW-1], err});
        mul_b      = VW'(dt);
        mul_neg    = err[VW-1];
        state_next = apfd_pkg::ST_IDIV_GO;
      end
      apfd_pkg::ST_IDIV_GO: begin
        div_req.start = 1'b1;
        div_req.num   = prod[DW-1:0] + DW'(apfd_pkg::US_PER_S / 2);
        div_req.den   = UW'(apfd_pkg::US_PER_S);
        state_next    = apfd_pkg::ST_IDIV;
      end
      apfd_pkg::ST_IDIV: begin
        if (div_rsp.done) state_next = apfd_pkg::ST_IUPD;
      end
      apfd_pkg::ST_IUPD: begin
        // derivative: |de| * 1e6 / dt, rounded half away from zero
        mul_a      = mag_of(diff);
        mul_b      = VW'(apfd_pkg::US_PER_S);
        mul_neg    = diff[VW];
        state_next = apfd_pkg::ST_DDIV_GO;
      end
      apfd_pkg::ST_DDIV_GO: begin
        div_req.start = 1'b1;
        div_req.num   = prod[DW-1:0] + DW'(dt >> 1);
        div_req.den   = UW'(dt);
        state_next    = apfd_pkg::ST_DDIV;
      end
      apfd_pkg::ST_DDIV: begin
        if (div_rsp.done) state_next = apfd_pkg::ST_FMUL0;
      end
      apfd_pkg::ST_FMUL0: begin
        mul_a      = VW'(alpha);
        mul_b      = mag_of({raw[VW-1], raw});
        mul_neg    = raw[VW-1];
        state_next = apfd_pkg::ST_FMUL1;
      end
      apfd_pkg::ST_FMUL1: begin
        mul_a      = VW'(ONE_Q - alpha);
        mul_b      = mag_of({smoothed_derivative[VW-1], smoothed_derivative});
        mul_neg    = smoothed_derivative[VW-1];
        state_next = apfd_pkg::ST_FACC;
      end
      apfd_pkg::ST_FACC: begin
        state_next = apfd_pkg::ST_FUPD;
      end
      apfd_pkg::ST_FUPD: begin
        state_next = apfd_pkg::ST_GMUL_P;
      end
      apfd_pkg::ST_GMUL_P: begin
        mul_a      = mag_of({gain_p[VW-1], gain_p});
        mul_b      = mag_of({err[VW-1], err});
        mul_neg    = gain_p[VW-1] ^ err[VW-1];
        state_next = apfd_pkg::ST_GMUL_I;
      end
      apfd_pkg::ST_GMUL_I: begin
        mul_a      = mag_of({gain_i[VW-1], gain_i});
        mul_b      = mag_of({error_integral[VW-1], error_integral});
        mul_neg    = gain_i[VW-1] ^ error_integral[VW-1];
        state_next = apfd_pkg::ST_GMUL_D;
      end
      apfd_pkg::ST_GMUL_D: begin
        mul_a      = mag_of({gain_d[VW-1], gain_d});
        mul_b      = mag_of({smoothed_derivative[VW-1], smoothed_derivative});
        mul_neg    = gain_d[VW-1] ^ smoothed_derivative[VW-1];
        state_next = apfd_pkg::ST_GTERM;
      end
      apfd_pkg::ST_GTERM: begin
        state_next = apfd_pkg::ST_GSUM;
      end
      apfd_pkg::ST_GSUM: begin
        state_next = apfd_pkg::ST_FINAL;
      end
      apfd_pkg::ST_FINAL: begin
        if (out_free) state_next = apfd_pkg::ST_IDLE;
      end
      default: begin
        state_next = apfd_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- shared units
  always_ff @(posedge clk) begin
    prod     <= PW'(mul_a) * PW'(mul_b);
    prod_neg <= mul_neg;
  end

  apfd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------- work registers
  always_ff @(posedge clk) begin
    case (state)
      apfd_pkg::ST_IDLE: begin
        if (sample.valid) begin
          err <= sat_wide(WW'(altitude_target) - WW'(sample.altitude_sample));
          dt  <= dt_pick;
        end
      end
      apfd_pkg::ST_IMUL: begin
        diff <= (VW+1)'(err) - (VW+1)'(previous_error);
      end
      apfd_pkg::ST_IDIV: begin
        if (div_rsp.done) incr <= from_mag(err[VW-1], PW'(div_rsp.quot));
      end
      apfd_pkg::ST_DDIV: begin
        if (div_rsp.done) raw <= from_mag(diff[VW], PW'(div_rsp.quot));
      end
      apfd_pkg::ST_FMUL1: begin
        acc <= signed_prod(prod_neg, prod) + AW'(ROUND_Q);
      end
      apfd_pkg::ST_FACC: begin
        acc <= acc + signed_prod(prod_neg, prod);
      end
      apfd_pkg::ST_GMUL_I: begin
        term <= gain_term(prod_neg, prod);
      end
      apfd_pkg::ST_GMUL_D: begin
        term <= gain_term(prod_neg, prod);
        sum  <= SW'(term);
      end
      apfd_pkg::ST_GTERM: begin
        term <= gain_term(prod_neg, prod);
        sum  <= sum + SW'(term);
      end
      apfd_pkg::ST_GSUM: begin
        sum <= sum + SW'(term);
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      altitude_target     <= '0;
      gain_p              <= $signed(apfd_pkg::RST_GAIN_P);
      gain_i              <= '0;
      gain_d              <= '0;
      integral_limit      <= apfd_pkg::RST_INTEGRAL_LIMIT;
      drive_limit         <= $signed(apfd_pkg::RST_DRIVE_LIMIT);
      smoothing_weight    <= apfd_pkg::RST_SMOOTHING_WEIGHT;
      awaiting_first      <= 1'b1;
      previous_time_us    <= '0;
      error_integral      <= '0;
      previous_error      <= '0;
      smoothed_derivative <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.reg_index)
          apfd_pkg::REG_ALTITUDE_TARGET:  altitude_target  <= $signed(cfg.wdata);
          apfd_pkg::REG_GAIN_P:           gain_p           <= $signed(cfg.wdata);
          apfd_pkg::REG_GAIN_I:           gain_i           <= $signed(cfg.wdata);
          apfd_pkg::REG_GAIN_D:           gain_d           <= $signed(cfg.wdata);
          apfd_pkg::REG_INTEGRAL_LIMIT:   integral_limit   <= cfg.wdata[ILW-1:0];
          apfd_pkg::REG_DRIVE_LIMIT:      drive_limit      <= $signed(cfg.wdata);
          apfd_pkg::REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg.wdata[ALW-1:0];
          default: begin
          end
        endcase
      end

      // a new word may load in the same cycle the held one leaves
      if ((state == apfd_pkg::ST_FINAL) && out_free) begin
        out_valid <= 1'b1;
      end else if (drive.valid && drive.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        apfd_pkg::ST_IDLE: begin
          if (sample.valid) begin
            awaiting_first   <= 1'b0;
            previous_time_us <= sample.sample_time_us;
          end
        end
        apfd_pkg::ST_IMUL: begin
          previous_error <= err;
        end
        apfd_pkg::ST_IUPD: begin
          error_integral <= int_clamped;
        end
        apfd_pkg::ST_FUPD: begin
          smoothed_derivative <= sat_wide(WW'(acc >>> FB));
        end
        default: begin
        end
      endcase
    end
  end

  // output word: upper clamp only
  always_ff @(posedge clk) begin
    if ((state == apfd_pkg::ST_FINAL) && out_free) begin
      if (drive_sat > drive_limit) begin
        drive_value_q   <= drive_limit;
        drive_clamped_q <= 1'b1;
      end else begin
        drive_value_q   <= drive_sat;
        drive_clamped_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- assertions
  `APFD_ASSERT_NOW(a_dt_range, state != apfd_pkg::ST_IDLE, (dt != '0) && (dt <= DTW'(apfd_pkg::DT_MAX)), "time step out of range while busy")
  `APFD_ASSERT_NOW(a_div_done_wait, div_rsp.done, (state == apfd_pkg::ST_IDIV) || (state == apfd_pkg::ST_DDIV), "divider finished outside a wait state")
  `APFD_ASSERT_NEXT(a_accept_starts, sample.valid && sample.ready, state == apfd_pkg::ST_IMUL, "accepted word did not start the sequence")
  `APFD_ASSERT_NOW(a_result_from_final, $rose(drive.valid), $past(state) == apfd_pkg::ST_FINAL, "drive word appeared outside the final step")

endmodule

`default_nettype wire
